// ===== design/fbfla_pkg.sv =====
// Shared types and codes for the fixed block free list allocator.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package fbfla_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_ALLOCATED  = 3'd0,
    STAT_EMPTY      = 3'd1,
    STAT_FREED      = 3'd2,
    STAT_RANGE      = 3'd3,
    STAT_NOT_ALLOC  = 3'd4
  } status_t;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] free_offset;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] block_index;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_DIV,
    S_FREE
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;      // capture request, start divide
    logic    div_step;  // one reciprocal multiply step
    logic    rd_quo;    // memory read address is the quotient (else head)
    logic    commit;    // apply result and load the response register
    status_t result;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic head_valid;
    logic div_done;
    logic in_range;
    logic blk_alloc;
    logic slot_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/fbfla_ctrl.sv =====
// Sequencing controller for the allocator.
// Depends on fbfla_pkg; drives command struct to fbfla_dpath.
`timescale 1ns / 1ps
`default_nettype none

module fbfla_ctrl import fbfla_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  input  wire logic     req_kind,
  output logic          req_stall,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.result   = STAT_EMPTY;
    req_stall    = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = (req_kind == KIND_FREE) ? S_DIV : S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.result = stat.head_valid ? STAT_ALLOCATED : STAT_EMPTY;
        if (stat.slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.rd_quo = 1'b1;
        if (stat.div_done) begin
          state_next = S_FREE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FREE: begin
        cmd.rd_quo = 1'b1;
        priority if (!stat.in_range) begin
          cmd.result = STAT_RANGE;
        end else if (!stat.blk_alloc) begin
          cmd.result = STAT_NOT_ALLOC;
        end else begin
          cmd.result = STAT_FREED;
        end
        if (stat.slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/fbfla_dpath.sv =====
// Datapath: link memory, list head, fill count, offset divider, response register.
// Depends on fbfla_pkg; commanded by fbfla_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module fbfla_dpath import fbfla_pkg::*; #(
  parameter int BLOCK_COUNT = 256,
  parameter int BLOCK_BYTES = 2048
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire req_t    req,
  input  wire dp_cmd_t cmd,
  output dp_stat_t     stat,
  output logic         rsp_valid,
  input  wire logic    rsp_stall,
  output rsp_t         rsp
);

  localparam int IDX_W  = $clog2(BLOCK_COUNT);
  localparam int FILL_W = IDX_W + 1;
  localparam int DW     = 32 + IDX_W;
  localparam int WORD_W = IDX_W + 2;
  localparam int SHIFT  = $clog2(BLOCK_BYTES);
  localparam bit BYTES_POW2 = ((BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0);
  localparam logic [DW-1:0] POOL_BYTES = DW'(BLOCK_COUNT) * DW'(BLOCK_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_COUNT - 1);

  // word: {allocated, last, next}
  logic [WORD_W-1:0] mem [BLOCK_COUNT];
  logic [WORD_W-1:0] rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [IDX_W-1:0]  head;
  logic              head_valid;
  logic [FILL_W-1:0] fill;
  logic [31:0]       off_q;
  logic [IDX_W-1:0]  quo;
  logic              div_done;

  logic              pristine;
  logic              w_alloc;
  logic              w_last;
  logic [IDX_W-1:0]  w_next;

  // Offset to block index
  generate
    if (BYTES_POW2) begin : g_shift
      logic [DW-1:0] off_ext;
      assign off_ext  = DW'(off_q);
      assign quo      = IDX_W'(off_ext >> SHIFT);
      assign div_done = 1'b1;
    end else begin : g_recip
      // q = (x * M) >> (32 + L), M = ceil(2^(32+L) / BLOCK_BYTES): exact for any
      // 32-bit x. M fits 34 bits; two 17-bit halves, high half first.
      localparam int          L        = $clog2(BLOCK_BYTES);
      localparam int          SH       = 32 + L;
      localparam logic [63:0] RECIP    = ((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1)
                                         / 64'(BLOCK_BYTES);
      localparam logic [16:0] RECIP_HI = RECIP[33:17];
      localparam logic [16:0] RECIP_LO = RECIP[16:0];
      logic [65:0] acc;
      logic [16:0] m_part;
      logic [48:0] prod;
      logic [1:0]  steps_left;

      assign m_part = (steps_left == 2'd2) ? RECIP_HI : RECIP_LO;
      assign prod   = 49'(off_q) * 49'(m_part);

      always_ff @(posedge clk) begin
        if (cmd.load) begin
          acc        <= '0;
          steps_left <= 2'd2;
        end else if (cmd.div_step) begin
          acc        <= (acc << 17) + 66'(prod);
          steps_left <= steps_left - 2'd1;
        end
      end

      assign quo      = IDX_W'(acc >> SH);
      assign div_done = (steps_left == 2'd0);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      off_q <= req.free_offset;
    end
  end

  // Link memory, registered read
  assign rd_addr = cmd.rd_quo ? quo : head;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Entries at or above the fill count were never written: use reset contents
  assign pristine = ({1'b0, rd_addr} >= fill);
  assign w_alloc  = pristine ? 1'b0 : rd_q[IDX_W+1];
  assign w_last   = pristine ? (rd_addr == LAST_IDX) : rd_q[IDX_W];
  assign w_next   = pristine ? (rd_addr + IDX_W'(1)) : rd_q[IDX_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head;
    wr_data = {1'b1, w_last, w_next};
    unique case (cmd.result)
      STAT_ALLOCATED: begin
        wr_en = cmd.commit;
      end
      STAT_FREED: begin
        wr_en   = cmd.commit;
        wr_addr = quo;
        wr_data = {1'b0, !head_valid, head};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // List head, fill count, response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      head_valid <= 1'b1;
      fill       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
        if (cmd.result == STAT_ALLOCATED) begin
          if (w_last) begin
            head_valid <= 1'b0;
          end else begin
            head <= w_next;
          end
          if (pristine) begin
            fill <= fill + FILL_W'(1);
          end
        end else if (cmd.result == STAT_FREED) begin
          head       <= quo;
          head_valid <= 1'b1;
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.status      <= cmd.result;
      rsp.block_index <= (cmd.result == STAT_ALLOCATED) ? 8'(head) : 8'd0;
    end
  end

  assign stat.head_valid = head_valid;
  assign stat.div_done   = div_done;
  assign stat.in_range   = (DW'(off_q) < POOL_BYTES);
  assign stat.blk_alloc  = w_alloc;
  assign stat.slot_free  = !rsp_valid || !rsp_stall;

endmodule

`default_nettype wire

// ===== design/fixed_block_free_list_allocator.sv =====
// Fixed-size block free list allocator, top level (controller + datapath).
// Allocate: request capture with link read, then commit.
// Free: request capture, then the block index (a shift when BLOCK_BYTES is a power
//   of two, else the two-step reciprocal multiply), the registered link read, and commit.
// Reset: synchronous; list head 0, list full, response empty. No clearing pass:
//   a fill count marks which link entries still hold their reset contents.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_free_list_allocator import fbfla_pkg::*; #(
  parameter int BLOCK_COUNT = 256,
  parameter int BLOCK_BYTES = 2048
) (
  input  wire logic clk,
  input  wire logic rst,
  // request transaction
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  // response transaction
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: one request in flight; the response register lets a new
  // request be taken while the previous response is still stalled.
  fbfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .req_stall (req_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath: link memory with allocated flag, list head, divider,
  // response register.
  fbfla_dpath #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== dv/fixed_block_free_list_allocator_test.sv =====
// Testbench for fixed_block_free_list_allocator: directed and random alloc/free traffic,
// with a scoreboard class that tracks the free list and checks every response.
// Depends on fbfla_pkg and the allocator top level.
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_test;
  import fbfla_pkg::*;

  localparam int BLOCK_COUNT = 256;
  localparam int BLOCK_BYTES = 2048;
  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT = 100000;   // watchdog limit on the whole run
  localparam int HOLD_CYCLES = 250;      // one long receiver hold-off
  localparam int DRAIN_CYCLES = 20;      // settle time after the last response

  // Tracks the pool the way the block should: LIFO free list, last-entry flags and
  // the allocated map. Each accepted request queues the response it must produce.
  class pool_scoreboard;
    int unsigned head;
    bit head_ok;
    int unsigned link [BLOCK_COUNT];
    bit tail [BLOCK_COUNT];
    bit held [BLOCK_COUNT];
    int held_count;
    fbfla_pkg::rsp_t outcome_q [$];
    int errors;

    function new();
      head = 0;
      head_ok = 1'b1;
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        link[i] = (i + 1) % BLOCK_COUNT;
        tail[i] = (i == BLOCK_COUNT - 1);
        held[i] = 1'b0;
      end
      held_count = 0;
      errors = 0;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    // Random block that is currently handed out; caller checks held_count first.
    function int unsigned pick_held();
      int unsigned idx;
      idx = $urandom_range(0, BLOCK_COUNT - 1);
      while (!held[idx]) idx = $urandom_range(0, BLOCK_COUNT - 1);
      return idx;
    endfunction

    function void note_request(fbfla_pkg::req_t r);
      fbfla_pkg::rsp_t want;
      int unsigned blk;
      want.status = fbfla_pkg::STAT_EMPTY;
      want.block_index = '0;
      if (r.kind == fbfla_pkg::KIND_ALLOC) begin
        if (head_ok && head < BLOCK_COUNT) begin
          want.status = fbfla_pkg::STAT_ALLOCATED;
          want.block_index = 8'(head);
          held[head] = 1'b1;
          held_count++;
          if (tail[head]) head_ok = 1'b0;
          else head = link[head];
        end
      end else begin
        blk = r.free_offset / BLOCK_BYTES;
        if (blk >= BLOCK_COUNT) begin
          want.status = fbfla_pkg::STAT_RANGE;
        end else if (!held[blk]) begin
          want.status = fbfla_pkg::STAT_NOT_ALLOC;
        end else begin
          link[blk] = head;
          tail[blk] = !head_ok;
          head = blk;
          head_ok = 1'b1;
          held[blk] = 1'b0;
          held_count--;
          want.status = fbfla_pkg::STAT_FREED;
        end
      end
      outcome_q.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_response(fbfla_pkg::rsp_t got);
      fbfla_pkg::rsp_t want;
      if (outcome_q.size() == 0) begin
        report($sformatf("response with nothing outstanding: status %0d index %0d",
                         got.status, got.block_index));
      end else begin
        want = outcome_q.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.block_index !== want.block_index)
          report($sformatf("block_index %0d, want %0d", got.block_index, want.block_index));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  pool_scoreboard sb = new();

  int cycles = 0;
  int n_rsp = 0;

  fixed_block_free_list_allocator #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost response ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fixed_block_free_list_allocator_test: FAIL");
      $finish;
    end
  end

  // Response monitor: sampled at the rising edge, so pre-edge values are seen.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_response(rsp);
      n_rsp <= n_rsp + 1;
    end
  end

  // Receiver: random stalls (about 6%), a quiet stretch with none, and one long
  // hold-off so the response slot fills and req_stall has to back up the sender.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && n_rsp >= 60) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (n_rsp >= 250 && n_rsp < 370) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < 6);
      end
    end
  end

  // Offer one transaction; called just after a falling edge. Returns after the
  // next falling edge once the request has been taken. valid is written once per
  // step, so back-to-back transactions keep it high.
  task automatic send_req(input logic k, input logic [31:0] off, input bit quiet);
    req_t r;
    r.kind = k;
    r.free_offset = off;
    while (!quiet && $urandom_range(0, 99) < 6) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
    @(negedge clk);
  endtask

  initial begin
    bit filling;
    int extra;
    int pct_alloc;
    int sel;
    logic [31:0] off;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: rejects on a fresh pool, range boundaries, LIFO reuse,
    // misaligned offsets and double frees.
    send_req(KIND_FREE, 32'h0000_0000, 1'b0);   // block 0 never allocated
    send_req(KIND_FREE, 32'hFFFF_FFFF, 1'b0);   // far out of range
    send_req(KIND_FREE, 32'(BLOCK_COUNT * BLOCK_BYTES), 1'b0);      // first index past the end
    send_req(KIND_FREE, 32'(BLOCK_COUNT * BLOCK_BYTES - 1), 1'b0);  // last block, still free
    send_req(KIND_ALLOC, 32'hFFFF_FFFF, 1'b0);  // offset ignored on alloc
    send_req(KIND_ALLOC, 32'h0000_0000, 1'b0);
    send_req(KIND_FREE, 32'(BLOCK_BYTES - 1), 1'b0);  // misaligned, lands in block 0
    send_req(KIND_FREE, 32'h0000_0000, 1'b0);         // double free of block 0
    send_req(KIND_ALLOC, 32'h0, 1'b0);                // LIFO: block 0 again
    send_req(KIND_FREE, 32'(BLOCK_BYTES + 3), 1'b0);  // block 1
    send_req(KIND_FREE, 32'(BLOCK_BYTES), 1'b0);      // block 1 again, rejected
    send_req(KIND_ALLOC, 32'h0, 1'b0);
    send_req(KIND_FREE, 32'h8000_0000, 1'b0);
    send_req(KIND_FREE, 32'h0008_07FF, 1'b0);         // last byte of the first block past the pool
    send_req(KIND_FREE, 32'h0000_8000, 1'b0);         // block 16, never allocated
    send_req(KIND_ALLOC, 32'h5555_AAAA, 1'b0);

    // Random: alternate fill and drain phases so the pool runs dry (empty allocs,
    // frees into an empty list) and then refills. Most frees name a live block.
    filling = 1'b1;
    extra = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (filling && sb.held_count == BLOCK_COUNT) begin
        extra++;
        if (extra >= 4) begin
          filling = 1'b0;
          extra = 0;
        end
      end
      if (!filling && sb.held_count <= 4) filling = 1'b1;
      pct_alloc = filling ? 95 : 15;

      if ($urandom_range(0, 99) < pct_alloc) begin
        send_req(KIND_ALLOC, $urandom, (n >= 200 && n < 320));
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 7 && sb.held_count > 0)
          off = 32'(sb.pick_held() * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1));
        else if (sel == 7)
          off = $urandom;
        else if (sel == 8)
          off = 32'($urandom_range(0, BLOCK_COUNT - 1) * BLOCK_BYTES
                    + $urandom_range(0, BLOCK_BYTES - 1));
        else
          off = 32'(BLOCK_COUNT * BLOCK_BYTES + $urandom_range(0, 3 * BLOCK_BYTES));
        send_req(KIND_FREE, off, (n >= 200 && n < 320));
      end
    end
    req_valid <= 1'b0;

    // Wait out every outstanding response, then a few more cycles for strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("fixed_block_free_list_allocator_test: PASS");
    end else begin
      $display("fixed_block_free_list_allocator_test: FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/fbfla_pkg.sv
design/fbfla_ctrl.sv
design/fbfla_dpath.sv
design/fixed_block_free_list_allocator.sv
dv/fixed_block_free_list_allocator_test.sv
